/* design/rthc_pkg.sv */
package rthc_pkg;

	localparam int PIX_W   = 8;
	localparam int HUE_W   = 15;
	localparam int SAT_W   = 13;
	localparam int THR_W   = 13;
	localparam int FAM_W   = 4;
	localparam int LVL_W   = 2;

	// reciprocal divider: num < 2**FRAC_SHIFT, rcp = floor(2**FRAC_SHIFT / den)
	localparam int NUM_W      = 20;
	localparam int RCP_W      = 21;
	localparam int FRAC_SHIFT = 20;
	localparam int Q_W        = 13;
	localparam int TAB_DEPTH  = 256;

	localparam int NUM_STG = 7;

	localparam logic [THR_W-1:0] THR_RESET = 13'd410;

	// hue in degrees times 64
	localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
	localparam logic [HUE_W-1:0] HUE_BASE_R = 15'd0;
	localparam logic [HUE_W-1:0] HUE_BASE_G = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_BASE_B = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
	localparam logic [HUE_W-1:0] HUE_MAX    = 15'd23039;

	localparam logic [HUE_W-1:0] HUE_ORANGE = 15'd960;
	localparam logic [HUE_W-1:0] HUE_YELLOW = 15'd2880;
	localparam logic [HUE_W-1:0] HUE_GREEN  = 15'd4480;
	localparam logic [HUE_W-1:0] HUE_CYAN   = 15'd10240;
	localparam logic [HUE_W-1:0] HUE_BLUE   = 15'd12800;
	localparam logic [HUE_W-1:0] HUE_PURPLE = 15'd16640;
	localparam logic [HUE_W-1:0] HUE_PINK   = 15'd18560;
	localparam logic [HUE_W-1:0] HUE_RED_HI = 15'd22080;

	localparam logic [FAM_W-1:0] FAM_GRAY   = 4'd0;
	localparam logic [FAM_W-1:0] FAM_RED    = 4'd1;
	localparam logic [FAM_W-1:0] FAM_ORANGE = 4'd2;
	localparam logic [FAM_W-1:0] FAM_YELLOW = 4'd3;
	localparam logic [FAM_W-1:0] FAM_GREEN  = 4'd4;
	localparam logic [FAM_W-1:0] FAM_CYAN   = 4'd5;
	localparam logic [FAM_W-1:0] FAM_BLUE   = 4'd6;
	localparam logic [FAM_W-1:0] FAM_PURPLE = 4'd7;
	localparam logic [FAM_W-1:0] FAM_PINK   = 4'd8;

	localparam logic [LVL_W-1:0] TEMP_NEUTRAL = 2'd0;
	localparam logic [LVL_W-1:0] TEMP_WARM    = 2'd1;
	localparam logic [LVL_W-1:0] TEMP_COOL    = 2'd2;

	localparam logic [LVL_W-1:0] SLVL_MUTED = 2'd0;
	localparam logic [LVL_W-1:0] SLVL_SOFT  = 2'd1;
	localparam logic [LVL_W-1:0] SLVL_VIVID = 2'd2;

	// per-pixel data riding alongside the dividers
	typedef struct packed {
		logic [PIX_W-1:0] mx;
		logic             dzero;
		logic             hneg;
		logic [HUE_W-1:0] base;
		logic             gray;
		logic [LVL_W-1:0] slevel;
	} side_t;

endpackage

/* design/rthc_pix_if.sv */
interface rthc_pix_if;
	logic                          valid;
	logic                          ready;
	logic [rthc_pkg::PIX_W-1:0]    red;
	logic [rthc_pkg::PIX_W-1:0]    green;
	logic [rthc_pkg::PIX_W-1:0]    blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

/* design/rthc_hsv_if.sv */
interface rthc_hsv_if;
	logic                          valid;
	logic                          ready;
	logic [rthc_pkg::HUE_W-1:0]    hue;
	logic [rthc_pkg::SAT_W-1:0]    saturation;
	logic [rthc_pkg::PIX_W-1:0]    value;
	logic [rthc_pkg::FAM_W-1:0]    family;
	logic [rthc_pkg::LVL_W-1:0]    temperature;
	logic [rthc_pkg::LVL_W-1:0]    brightness_level;
	logic [rthc_pkg::LVL_W-1:0]    saturation_level;

	modport source (output valid, hue, saturation, value, family, temperature,
		brightness_level, saturation_level, input ready);
	modport sink (input valid, hue, saturation, value, family, temperature,
		brightness_level, saturation_level, output ready);
endinterface

/* design/rthc_cfg_if.sv */
interface rthc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rthc_pkg::THR_W-1:0]    data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* design/rthc_front.sv */
module rthc_front (
	input  logic                          clk,
	input  logic [1:0]                    en,
	input  logic [rthc_pkg::PIX_W-1:0]    red,
	input  logic [rthc_pkg::PIX_W-1:0]    green,
	input  logic [rthc_pkg::PIX_W-1:0]    blue,
	input  logic [rthc_pkg::THR_W-1:0]    thr,
	output logic [rthc_pkg::NUM_W-1:0]    n_sat_s2,
	output logic [rthc_pkg::NUM_W-1:0]    n_hue_s2,
	output logic [rthc_pkg::PIX_W-1:0]    d_s2,
	output logic [rthc_pkg::PIX_W-1:0]    mx_s2,
	output rthc_pkg::side_t               side_s2
);

	logic [rthc_pkg::PIX_W-1:0] mx, mn, mag;
	logic                       neg;
	logic [rthc_pkg::HUE_W-1:0] base;

	logic [rthc_pkg::PIX_W-1:0] mx_s1, d_s1, mag_s1;
	logic                       neg_s1;
	logic [rthc_pkg::HUE_W-1:0] base_s1;

	logic [20:0]                thr_mx;
	logic [14:0]                d100, mx65;

	// max with ties to red, then green; numerator magnitude and sign per sector
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (red >= green && red >= blue) begin
			neg  = green < blue;
			mag  = neg ? blue - green : green - blue;
			base = neg ? rthc_pkg::HUE_FULL : rthc_pkg::HUE_BASE_R;
		end else if (green >= blue) begin
			neg  = blue < red;
			mag  = neg ? red - blue : blue - red;
			base = rthc_pkg::HUE_BASE_G;
		end else begin
			neg  = red < green;
			mag  = neg ? green - red : red - green;
			base = rthc_pkg::HUE_BASE_B;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mx_s1   <= mx;
			d_s1    <= mx - mn;
			mag_s1  <= mag;
			neg_s1  <= neg;
			base_s1 <= base;
		end
	end

	assign thr_mx = 21'(thr) * 21'(mx_s1);
	assign d100   = 15'(d_s1) * 15'd100;
	assign mx65   = 15'(mx_s1) * 15'd65;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n_sat_s2 <= {d_s1, 12'd0};
			// negative offsets round up: floor((n + d - 1) / d)
			n_hue_s2 <= 20'(mag_s1) * 20'(rthc_pkg::HUE_SECTOR)
				+ (neg_s1 ? 20'(d_s1) - 20'd1 : 20'd0);
			d_s2           <= d_s1;
			mx_s2          <= mx_s1;
			side_s2.mx     <= mx_s1;
			side_s2.dzero  <= d_s1 == '0;
			side_s2.hneg   <= neg_s1;
			side_s2.base   <= base_s1;
			side_s2.gray   <= {1'b0, d_s1, 12'd0} < thr_mx;
			if ({d_s1, 2'b00} < {2'b00, mx_s1}) begin
				side_s2.slevel <= rthc_pkg::SLVL_MUTED;
			end else if (d100 < mx65) begin
				side_s2.slevel <= rthc_pkg::SLVL_SOFT;
			end else begin
				side_s2.slevel <= rthc_pkg::SLVL_VIVID;
			end
		end
	end

endmodule

/* design/rthc_div.sv */
module rthc_div (
	input  logic                          clk,
	input  logic [3:0]                    en,
	input  logic [rthc_pkg::NUM_W-1:0]    num,
	input  logic [rthc_pkg::PIX_W-1:0]    den,
	output logic [rthc_pkg::Q_W-1:0]      q_s6
);

	localparam int PRD_W = rthc_pkg::NUM_W + rthc_pkg::RCP_W;

	logic [rthc_pkg::RCP_W-1:0] rcp_tab [rthc_pkg::TAB_DEPTH];

	for (genvar i = 0; i < rthc_pkg::TAB_DEPTH; i++) begin : g_rcp
		localparam int unsigned DIVISOR = (i == 0) ? 1 : i;
		localparam logic [rthc_pkg::RCP_W-1:0] RCP = (i == 0) ? '0 :
			rthc_pkg::RCP_W'((64'd1 << rthc_pkg::FRAC_SHIFT) / DIVISOR);
		assign rcp_tab[i] = RCP;
	end

	logic [rthc_pkg::NUM_W-1:0] num_s3, num_s4, num_s5;
	logic [rthc_pkg::PIX_W-1:0] den_s3, den_s4, den_s5;
	logic [rthc_pkg::RCP_W-1:0] rcp_s3;
	logic [rthc_pkg::Q_W-1:0]   qe_s4, qe_s5;
	logic [rthc_pkg::NUM_W:0]   pq_s5;
	logic [PRD_W-1:0]           prd;
	logic [rthc_pkg::NUM_W-1:0] rem;

	assign prd = PRD_W'(num_s3) * PRD_W'(rcp_s3);
	// estimate is the true quotient or one below it
	assign rem = num_s5 - pq_s5[rthc_pkg::NUM_W-1:0];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			num_s3 <= num;
			den_s3 <= den;
			rcp_s3 <= rcp_tab[den];
		end
		if (en[1]) begin
			num_s4 <= num_s3;
			den_s4 <= den_s3;
			qe_s4  <= prd[rthc_pkg::FRAC_SHIFT +: rthc_pkg::Q_W];
		end
		if (en[2]) begin
			num_s5 <= num_s4;
			den_s5 <= den_s4;
			qe_s5  <= qe_s4;
			pq_s5  <= 21'(qe_s4) * 21'(den_s4);
		end
		if (en[3]) begin
			q_s6 <= qe_s5 + ((rem >= 20'(den_s5)) ? 13'd1 : 13'd0);
		end
	end

endmodule

/* design/rthc_class.sv */
module rthc_class (
	input  logic                          clk,
	input  logic                          en,
	input  rthc_pkg::side_t               side_s6,
	input  logic [rthc_pkg::Q_W-1:0]      qs_s6,
	input  logic [rthc_pkg::Q_W-1:0]      qh_s6,
	output logic [rthc_pkg::HUE_W-1:0]    hue_s7,
	output logic [rthc_pkg::SAT_W-1:0]    sat_s7,
	output logic [rthc_pkg::PIX_W-1:0]    val_s7,
	output logic [rthc_pkg::FAM_W-1:0]    fam_s7,
	output logic [rthc_pkg::LVL_W-1:0]    temp_s7,
	output logic [rthc_pkg::LVL_W-1:0]    bright_s7,
	output logic [rthc_pkg::LVL_W-1:0]    slvl_s7
);

	logic [rthc_pkg::HUE_W-1:0] hue;
	logic [rthc_pkg::FAM_W-1:0] fam;
	logic [rthc_pkg::LVL_W-1:0] temp;

	always_comb begin
		if (side_s6.dzero) begin
			hue = '0;
		end else if (side_s6.hneg) begin
			hue = side_s6.base - 15'(qh_s6);
		end else begin
			hue = side_s6.base + 15'(qh_s6);
		end

		if (side_s6.gray) begin
			fam = rthc_pkg::FAM_GRAY;
		end else if (hue < rthc_pkg::HUE_ORANGE || hue >= rthc_pkg::HUE_RED_HI) begin
			fam = rthc_pkg::FAM_RED;
		end else if (hue < rthc_pkg::HUE_YELLOW) begin
			fam = rthc_pkg::FAM_ORANGE;
		end else if (hue < rthc_pkg::HUE_GREEN) begin
			fam = rthc_pkg::FAM_YELLOW;
		end else if (hue < rthc_pkg::HUE_CYAN) begin
			fam = rthc_pkg::FAM_GREEN;
		end else if (hue < rthc_pkg::HUE_BLUE) begin
			fam = rthc_pkg::FAM_CYAN;
		end else if (hue < rthc_pkg::HUE_PURPLE) begin
			fam = rthc_pkg::FAM_BLUE;
		end else if (hue < rthc_pkg::HUE_PINK) begin
			fam = rthc_pkg::FAM_PURPLE;
		end else begin
			fam = rthc_pkg::FAM_PINK;
		end

		case (fam)
			rthc_pkg::FAM_GRAY: temp = rthc_pkg::TEMP_NEUTRAL;
			rthc_pkg::FAM_RED, rthc_pkg::FAM_ORANGE, rthc_pkg::FAM_YELLOW,
			rthc_pkg::FAM_PINK: temp = rthc_pkg::TEMP_WARM;
			default: temp = rthc_pkg::TEMP_COOL;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s7    <= hue;
			sat_s7    <= (side_s6.mx == '0) ? '0 : qs_s6;
			val_s7    <= side_s6.mx;
			fam_s7    <= fam;
			temp_s7   <= temp;
			// level boundaries at 63/127/191 are the top two bits of max
			bright_s7 <= side_s6.mx[rthc_pkg::PIX_W-1 -: rthc_pkg::LVL_W];
			slvl_s7   <= side_s6.slevel;
		end
	end

endmodule

/* design/rgb_to_hsv_color_classifier.sv */
// RGB to HSV converter and color classifier. Takes one pixel per clock unless
// stalled, and returns one result per pixel through its stages (min/max and
// sector, numerators and label compares, then four stages of a
// reciprocal-table divider for saturation and hue, then family and
// temperature from the hue). Each stage holds when the stage after it is full
// and stalled, so backpressure on the result channel fills the pipeline before
// pixel.ready drops. The gray threshold register resets to 410 and is written
// through cfg, which is always ready; write it only while the pipeline is empty.
module rgb_to_hsv_color_classifier (
	input  logic         clk,
	input  logic         arst_n,
	rthc_pix_if.sink     pixel,
	rthc_hsv_if.source   result,
	rthc_cfg_if.sink     cfg
);

	localparam int NS = rthc_pkg::NUM_STG;

	logic [NS:1]                vld_q;
	logic [NS:1]                en;
	logic [rthc_pkg::THR_W-1:0] thr_q;

	logic [rthc_pkg::NUM_W-1:0] n_sat_s2, n_hue_s2;
	logic [rthc_pkg::PIX_W-1:0] d_s2, mx_s2;
	rthc_pkg::side_t            side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [rthc_pkg::Q_W-1:0]   qs_s6, qh_s6;

	always_comb begin
		en[NS] = !vld_q[NS] || result.ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign pixel.ready = en[1];
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			thr_q <= rthc_pkg::THR_RESET;
		end else begin
			if (en[1]) vld_q[1] <= pixel.valid;
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
			if (cfg.valid) thr_q <= cfg.data;
		end
	end

	rthc_front u_front (
		.clk      (clk),
		.en       (en[2:1]),
		.red      (pixel.red),
		.green    (pixel.green),
		.blue     (pixel.blue),
		.thr      (thr_q),
		.n_sat_s2 (n_sat_s2),
		.n_hue_s2 (n_hue_s2),
		.d_s2     (d_s2),
		.mx_s2    (mx_s2),
		.side_s2  (side_s2)
	);

	rthc_div u_div_sat (
		.clk  (clk),
		.en   (en[6:3]),
		.num  (n_sat_s2),
		.den  (mx_s2),
		.q_s6 (qs_s6)
	);

	rthc_div u_div_hue (
		.clk  (clk),
		.en   (en[6:3]),
		.num  (n_hue_s2),
		.den  (d_s2),
		.q_s6 (qh_s6)
	);

	always_ff @(posedge clk) begin
		if (en[3]) side_s3 <= side_s2;
		if (en[4]) side_s4 <= side_s3;
		if (en[5]) side_s5 <= side_s4;
		if (en[6]) side_s6 <= side_s5;
	end

	rthc_class u_class (
		.clk       (clk),
		.en        (en[7]),
		.side_s6   (side_s6),
		.qs_s6     (qs_s6),
		.qh_s6     (qh_s6),
		.hue_s7    (result.hue),
		.sat_s7    (result.saturation),
		.val_s7    (result.value),
		.fam_s7    (result.family),
		.temp_s7   (result.temperature),
		.bright_s7 (result.brightness_level),
		.slvl_s7   (result.saturation_level)
	);

	assign result.valid = vld_q[NS];

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> vld_q[1])
		else $error("accepted pixel did not enter first stage");

	a_full_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> (&vld_q) && !result.ready)
		else $error("input stalled with a bubble in the pipeline");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.hue <= rthc_pkg::HUE_MAX)
		else $error("hue out of range");

	a_gray_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.family == rthc_pkg::FAM_GRAY) ==
		(result.temperature == rthc_pkg::TEMP_NEUTRAL)))
		else $error("gray family and neutral temperature disagree");

endmodule

/* tb/rgb_to_hsv_color_classifier_checker.sv */
module rgb_to_hsv_color_classifier_checker (
	input  logic  clk,
	input  logic  arst_n,
	rthc_pix_if   pixel,
	rthc_hsv_if   result,
	rthc_cfg_if   cfg,
	output int    fail_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [rthc_pkg::LVL_W-1:0] BRT_DARK     = 2'd0;
	localparam logic [rthc_pkg::LVL_W-1:0] BRT_DIM      = 2'd1;
	localparam logic [rthc_pkg::LVL_W-1:0] BRT_BALANCED = 2'd2;
	localparam logic [rthc_pkg::LVL_W-1:0] BRT_BRIGHT   = 2'd3;

	typedef struct packed {
		logic [rthc_pkg::HUE_W-1:0] hue;
		logic [rthc_pkg::SAT_W-1:0] saturation;
		logic [rthc_pkg::PIX_W-1:0] value;
		logic [rthc_pkg::FAM_W-1:0] family;
		logic [rthc_pkg::LVL_W-1:0] temperature;
		logic [rthc_pkg::LVL_W-1:0] brightness_level;
		logic [rthc_pkg::LVL_W-1:0] saturation_level;
	} hsv_class_t;

	hsv_class_t                 hsv_expected[$];
	logic [rthc_pkg::THR_W-1:0] gray_thr;

	// 60-degree sector fraction, rounded toward minus infinity for negative numerators
	function automatic int sector_offset(input int num, input int den);
		if (num >= 0)
			return (int'(rthc_pkg::HUE_SECTOR) * num) / den;
		return -((int'(rthc_pkg::HUE_SECTOR) * (-num) + den - 1) / den);
	endfunction

	function automatic hsv_class_t classify_pixel(input logic [rthc_pkg::PIX_W-1:0] r, g, b,
			input logic [rthc_pkg::THR_W-1:0] thr);
		hsv_class_t c;
		int ri, gi, bi, mx, mn, d, hue, sat, thr_i;
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		thr_i = int'(thr);
		mx = ri;
		mn = ri;
		if (gi > mx) mx = gi;
		if (bi > mx) mx = bi;
		if (gi < mn) mn = gi;
		if (bi < mn) mn = bi;
		d = mx - mn;
		sat = (mx > 0) ? (4096 * d) / mx : 0;
		hue = 0;
		if (d > 0) begin
			// red wins ties, then green
			if (mx == ri) begin
				if (gi >= bi)
					hue = int'(rthc_pkg::HUE_BASE_R) + sector_offset(gi - bi, d);
				else
					hue = int'(rthc_pkg::HUE_FULL) + sector_offset(gi - bi, d);
			end else if (mx == gi) begin
				hue = int'(rthc_pkg::HUE_BASE_G) + sector_offset(bi - ri, d);
			end else begin
				hue = int'(rthc_pkg::HUE_BASE_B) + sector_offset(ri - gi, d);
			end
		end
		c.hue = hue[rthc_pkg::HUE_W-1:0];
		c.saturation = sat[rthc_pkg::SAT_W-1:0];
		c.value = mx[rthc_pkg::PIX_W-1:0];

		if (4096 * d < thr_i * mx)
			c.family = rthc_pkg::FAM_GRAY;
		else if (hue < int'(rthc_pkg::HUE_ORANGE) || hue >= int'(rthc_pkg::HUE_RED_HI))
			c.family = rthc_pkg::FAM_RED;
		else if (hue < int'(rthc_pkg::HUE_YELLOW))
			c.family = rthc_pkg::FAM_ORANGE;
		else if (hue < int'(rthc_pkg::HUE_GREEN))
			c.family = rthc_pkg::FAM_YELLOW;
		else if (hue < int'(rthc_pkg::HUE_CYAN))
			c.family = rthc_pkg::FAM_GREEN;
		else if (hue < int'(rthc_pkg::HUE_BLUE))
			c.family = rthc_pkg::FAM_CYAN;
		else if (hue < int'(rthc_pkg::HUE_PURPLE))
			c.family = rthc_pkg::FAM_BLUE;
		else if (hue < int'(rthc_pkg::HUE_PINK))
			c.family = rthc_pkg::FAM_PURPLE;
		else
			c.family = rthc_pkg::FAM_PINK;

		case (c.family)
			rthc_pkg::FAM_GRAY: c.temperature = rthc_pkg::TEMP_NEUTRAL;
			rthc_pkg::FAM_RED, rthc_pkg::FAM_ORANGE, rthc_pkg::FAM_YELLOW,
			rthc_pkg::FAM_PINK: c.temperature = rthc_pkg::TEMP_WARM;
			default: c.temperature = rthc_pkg::TEMP_COOL;
		endcase

		if (4 * mx < 255)
			c.brightness_level = BRT_DARK;
		else if (2 * mx < 255)
			c.brightness_level = BRT_DIM;
		else if (4 * mx < 765)
			c.brightness_level = BRT_BALANCED;
		else
			c.brightness_level = BRT_BRIGHT;

		if (4 * d < mx)
			c.saturation_level = rthc_pkg::SLVL_MUTED;
		else if (100 * d < 65 * mx)
			c.saturation_level = rthc_pkg::SLVL_SOFT;
		else
			c.saturation_level = rthc_pkg::SLVL_VIVID;
		return c;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		hsv_class_t want;
		if (!arst_n) begin
			gray_thr = rthc_pkg::THR_RESET;
			hsv_expected.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				gray_thr = cfg.data;
			if (pixel.valid && pixel.ready)
				hsv_expected.push_back(classify_pixel(pixel.red, pixel.green, pixel.blue,
					gray_thr));
			if (result.valid && result.ready) begin
				if (hsv_expected.size() == 0) begin
					$error("result with no pixel request pending");
					fail_count++;
				end else begin
					want = hsv_expected.pop_front();
					check_field("hue", 32'(want.hue), 32'(result.hue));
					check_field("saturation", 32'(want.saturation),
						32'(result.saturation));
					check_field("value", 32'(want.value), 32'(result.value));
					check_field("family", 32'(want.family), 32'(result.family));
					check_field("temperature", 32'(want.temperature),
						32'(result.temperature));
					check_field("brightness_level", 32'(want.brightness_level),
						32'(result.brightness_level));
					check_field("saturation_level", 32'(want.saturation_level),
						32'(result.saturation_level));
				end
			end
			pending = hsv_expected.size();
		end
	end

endmodule

/* tb/rgb_to_hsv_color_classifier_tb.sv */
module rgb_to_hsv_color_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_PIXELS = 200;
	localparam int HOLD_CYCLES  = 80;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   rx_mode;
	bit   rx_hold_req;
	int   pixels_sent;
	int   thr_settings;

	rthc_pix_if pix_if();
	rthc_hsv_if hsv_if();
	rthc_cfg_if cfg_if();

	rgb_to_hsv_color_classifier u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_if),
		.result (hsv_if),
		.cfg    (cfg_if)
	);

	rgb_to_hsv_color_classifier_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pix_if),
		.result     (hsv_if),
		.cfg        (cfg_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[rgb_to_hsv_color_classifier] ERROR");
		$finish;
	end

	// result side: stall patterns per phase, plus a long hold on request
	initial begin
		int run;
		int cyc;
		hsv_if.ready = 1'b0;
		run = 0;
		cyc = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (rx_hold_req) begin
				hsv_if.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				rx_hold_req = 1'b0;
			end else begin
				case (rx_mode)
					0: hsv_if.ready <= 1'b1;
					1: hsv_if.ready <= ($urandom_range(0, 99) >= 30);
					2: begin
						if (run == 0) begin
							run = $urandom_range(1, 9);
							hsv_if.ready <= ~hsv_if.ready;
						end else begin
							run--;
						end
					end
					default: hsv_if.ready <= (cyc % 5 != 2) && (cyc % 7 != 0);
				endcase
			end
		end
	end

	function automatic logic [3*rthc_pkg::PIX_W-1:0] random_pixel();
		logic [rthc_pkg::PIX_W-1:0] a, b, c, lo;
		a = 8'($urandom_range(0, 255));
		b = 8'($urandom_range(0, 255));
		c = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			4: begin
				b = a;
				c = a;
			end
			5: begin
				a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				b = $urandom_range(0, 1) ? 8'hFF : b;
				c = $urandom_range(0, 1) ? 8'h00 : c;
			end
			6: begin
				lo = 8'($urandom_range(0, 252));
				a = 8'(lo + $urandom_range(0, 3));
				b = 8'(lo + $urandom_range(0, 3));
				c = 8'(lo + $urandom_range(0, 3));
			end
			7: begin
				a = 8'($urandom_range(1, 255));
				b = a;
				c = 8'($urandom_range(0, a));
			end
			8: a = 8'hFF;
			9: begin
				a = 8'($urandom_range(0, 15));
				b = 8'($urandom_range(0, 15));
				c = 8'($urandom_range(0, 15));
			end
			default: ;
		endcase
		case ($urandom_range(0, 2))
			0: return {a, b, c};
			1: return {c, a, b};
			default: return {b, c, a};
		endcase
	endfunction

	task automatic send_pixel(input logic [3*rthc_pkg::PIX_W-1:0] px);
		@(negedge clk);
		pix_if.valid <= 1'b1;
		{pix_if.red, pix_if.green, pix_if.blue} <= px;
		@(posedge clk);
		while (!pix_if.ready) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			pix_if.valid <= 1'b0;
		end
	endtask

	task automatic drain_results();
		idle_cycles(1);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic set_gray_threshold(input logic [rthc_pkg::THR_W-1:0] thr);
		drain_results();
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= thr;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		thr_settings++;
	endtask

	task automatic random_phase(input int n, input bit gaps);
		int sent;
		int burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < n; k++) begin
				send_pixel(random_pixel());
				sent++;
			end
			if (gaps)
				idle_cycles($urandom_range(1, 6));
		end
	endtask

	logic [3*rthc_pkg::PIX_W-1:0] directed_px [] = '{
		24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
		24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001,
		24'hFFFEFF, 24'hC83200, 24'hC83100, 24'h3F0000, 24'h400000,
		24'h7F7F00, 24'h800000, 24'hBF0000, 24'hC00000, 24'hC89696,
		24'h644123, 24'hFF8000, 24'hFF0080, 24'h8000FF, 24'h010000
	};

	logic [rthc_pkg::THR_W-1:0] thr_plan [] = '{
		13'd0, 13'd4096, 13'd4097, 13'd8191, 13'd0, 13'd0, 13'd410, 13'd1
	};

	initial begin
		arst_n = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.red = '0;
		pix_if.green = '0;
		pix_if.blue = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		rx_mode = 0;
		rx_hold_req = 1'b0;
		pixels_sent = 0;
		thr_settings = 1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset threshold first, then the corner pixels
		rx_mode = 1;
		foreach (directed_px[i])
			send_pixel(directed_px[i]);

		thr_plan[4] = 13'($urandom_range(1, 4095));
		thr_plan[5] = 13'($urandom_range(300, 3000));
		foreach (thr_plan[p]) begin
			set_gray_threshold(thr_plan[p]);
			rx_mode = p % 4;
			if (p == 2) begin
				// stall the result side long enough to back up the pixel input
				@(posedge clk);
				rx_hold_req = 1'b1;
				for (int k = 0; k < 40; k++)
					send_pixel(random_pixel());
			end
			random_phase(PHASE_PIXELS / 2, p != 0);
			if (p == 3)
				drain_results();
			random_phase(PHASE_PIXELS / 2, p != 0);
		end

		drain_results();
		repeat (2 * rthc_pkg::NUM_STG + 4) @(negedge clk);
		$display("run covered %0d pixels over %0d gray threshold settings", pixels_sent,
			thr_settings);
		if (fail_count == 0 && pending == 0) begin
			$display("[rgb_to_hsv_color_classifier] OK");
		end else begin
			$display("[rgb_to_hsv_color_classifier] ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
design/rthc_pkg.sv
design/rthc_pix_if.sv
design/rthc_hsv_if.sv
design/rthc_cfg_if.sv
design/rthc_front.sv
design/rthc_div.sv
design/rthc_class.sv
design/rgb_to_hsv_color_classifier.sv
tb/rgb_to_hsv_color_classifier_checker.sv
tb/rgb_to_hsv_color_classifier_tb.sv
